// ===== sv/tme_pkg.sv =====
package tme_pkg;

  // Tape geometry: the depth is a power of two, so pointer wrap is free.
  localparam int TAPE_AW    = 15;
  localparam int TAPE_DEPTH = 1 << TAPE_AW;
  localparam int CELL_W     = 8;

  localparam int PROGRAM_DEPTH = 4096;
  localparam int IDX_W         = $clog2(PROGRAM_DEPTH + 1);

  localparam int FUNC_W  = 3;
  localparam int DIST_W  = 12;
  localparam int START_W = 15;

  localparam logic [START_W-1:0] START_CELL_RESET = START_W'(16384);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RIGHT = 3'd0,
    FUNC_LEFT  = 3'd1,
    FUNC_INC   = 3'd2,
    FUNC_DEC   = 3'd3,
    FUNC_OUT   = 3'd4,
    FUNC_IN    = 3'd5,
    FUNC_JZ    = 3'd6,
    FUNC_JNZ   = 3'd7
  } func_t;

  // Start cell reduced modulo the tape depth.
  function automatic logic [TAPE_AW-1:0] start_to_ptr(input logic [START_W-1:0] v);
    logic [31:0] ext;
    ext = 32'(v);
    return ext[TAPE_AW-1:0];
  endfunction

endpackage

// ===== sv/tme_ram.sv =====
module tme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/tape_machine_executor.sv =====
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | in_func, in_jump_distance, in_in_byte
// out     | output    | out_valid/out_ready| out_next_index, out_out_byte, out_out_valid
// cfg     | input     | cfg_we             | cfg_wdata (start cell)
//
// From acceptance to result, each instruction has the tape RAM read in the first stage,
// then modify, write-back and the output register load in the second.
// A new instruction is accepted every cycle while the output does not stall; a
// write-back to the cell read by the following instruction is forwarded.
// After reset the tape is cleared one cell per cycle, all 32768 cells, with in_ready low.
// A stalled output holds the second stage, which in turn holds in_ready low.
module tape_machine_executor
  import tme_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [DIST_W-1:0]   in_jump_distance,
  input  logic [CELL_W-1:0]   in_in_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IDX_W-1:0]    out_next_index,
  output logic [CELL_W-1:0]   out_out_byte,
  output logic                out_out_valid,
  input  logic                cfg_we,
  input  logic [START_W-1:0]  cfg_wdata
);

  localparam int SUM_W = ((IDX_W > DIST_W) ? IDX_W : DIST_W) + 1;
  localparam logic [SUM_W-1:0] PD = SUM_W'(PROGRAM_DEPTH);

  // Clearing pass
  logic               clr_busy_r;
  logic [TAPE_AW-1:0] clr_addr_r;

  // Architectural state
  logic [TAPE_AW-1:0] ptr_r, ptr_nxt;
  logic [IDX_W-1:0]   idx_r;

  // Second stage
  logic               s1_valid_r;
  func_t              s1_func_r;
  logic [DIST_W-1:0]  s1_dist_r;
  logic [CELL_W-1:0]  s1_byte_r;
  logic [TAPE_AW-1:0] s1_addr_r;
  logic               s1_fwd_r;
  logic [CELL_W-1:0]  s1_fwd_data_r;

  // Output register
  logic               out_valid_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic [CELL_W-1:0]  out_ob_r;
  logic               out_ov_r;

  logic               in_accept;
  logic               s1_fire;
  logic               s1_we;
  logic [CELL_W-1:0]  ram_rdata;
  logic [CELL_W-1:0]  cur_cell;
  logic [CELL_W-1:0]  wdata;
  logic [SUM_W-1:0]   base_raw, base, dist_ext, fwd_sum, next_sum;
  logic [IDX_W-1:0]   next_idx;

  logic               ram_we;
  logic [TAPE_AW-1:0] ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !clr_busy_r && (!s1_valid_r || s1_fire);
  assign in_accept = in_valid && in_ready;

  assign cur_cell = s1_fwd_r ? s1_fwd_data_r : ram_rdata;

  always_comb begin
    s1_we = 1'b0;
    wdata = cur_cell;
    unique case (s1_func_r)
      FUNC_INC: begin
        s1_we = 1'b1;
        wdata = cur_cell + CELL_W'(1);
      end
      FUNC_DEC: begin
        s1_we = 1'b1;
        wdata = cur_cell - CELL_W'(1);
      end
      FUNC_IN: begin
        s1_we = 1'b1;
        wdata = s1_byte_r;
      end
      default: begin
        s1_we = 1'b0;
        wdata = cur_cell;
      end
    endcase
  end

  // Next instruction index with saturation at both ends of the program.
  always_comb begin
    base_raw = SUM_W'(idx_r) + SUM_W'(1);
    base     = (base_raw > PD) ? PD : base_raw;
    dist_ext = SUM_W'(s1_dist_r);
    fwd_sum  = base + dist_ext;
    next_sum = base;
    if (s1_func_r == FUNC_JZ && cur_cell == '0) begin
      next_sum = (fwd_sum > PD) ? PD : fwd_sum;
    end else if (s1_func_r == FUNC_JNZ && cur_cell != '0) begin
      next_sum = (dist_ext > base) ? '0 : base - dist_ext;
    end
    next_idx = next_sum[IDX_W-1:0];
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cfg_we) begin
      ptr_nxt = start_to_ptr(cfg_wdata);
    end else if (in_accept) begin
      if (func_t'(in_func) == FUNC_RIGHT) begin
        ptr_nxt = ptr_r + TAPE_AW'(1);
      end else if (func_t'(in_func) == FUNC_LEFT) begin
        ptr_nxt = ptr_r - TAPE_AW'(1);
      end
    end
  end

  always_comb begin
    if (clr_busy_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_fire && s1_we;
      ram_waddr = s1_addr_r;
      ram_wdata = wdata;
    end
  end

  tme_ram #(
    .WIDTH (CELL_W),
    .DEPTH (TAPE_DEPTH)
  ) u_tape (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      ptr_r       <= start_to_ptr(START_CELL_RESET);
      idx_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + TAPE_AW'(1);
        if (clr_addr_r == '1) begin
          clr_busy_r <= 1'b0;
        end
      end
      ptr_r <= ptr_nxt;
      if (s1_fire) begin
        idx_r <= next_idx;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func_r <= func_t'(in_func);
      s1_dist_r <= in_jump_distance;
      s1_byte_r <= in_in_byte;
      s1_addr_r <= ptr_r;
      // The RAM returns the old cell when the previous instruction writes it
      // in the same cycle, so the written value is carried along instead.
      s1_fwd_r      <= s1_fire && s1_we && (s1_addr_r == ptr_r);
      s1_fwd_data_r <= wdata;
    end
    if (s1_fire) begin
      out_idx_r <= next_idx;
      out_ob_r  <= (s1_func_r == FUNC_OUT) ? cur_cell : '0;
      out_ov_r  <= (s1_func_r == FUNC_OUT);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_next_index = out_idx_r;
  assign out_out_byte   = out_ob_r;
  assign out_out_valid  = out_ov_r;

endmodule

// ===== sv/tme_checker.sv =====
module tme_checker
  import tme_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [IDX_W-1:0]   out_next_index,
  input logic [CELL_W-1:0]  out_out_byte,
  input logic               out_out_valid
);

  // The tape clear keeps the input closed right after reset.
  a_closed_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("in_ready high right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_index)
      && $stable(out_out_byte) && $stable(out_out_valid))
    else $error("stalled result changed");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_next_index <= IDX_W'(PROGRAM_DEPTH))
    else $error("next index beyond program end");

  a_byte_only_on_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_valid |-> out_out_byte == '0)
    else $error("output byte set without output flag");

  // A result rises only after a transaction was accepted and passed the second stage,
  // or after an earlier stalled result held the second stage.
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(out_valid, 2))
    else $error("result without an accepted transaction");

endmodule

bind tape_machine_executor tme_checker u_tme_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_next_index (out_next_index),
  .out_out_byte   (out_out_byte),
  .out_out_valid  (out_out_valid)
);

// ===== sim/tb_tape_machine_executor.sv =====
module tb_tape_machine_executor
  import tme_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    func_t               op;
    logic [DIST_W-1:0]   distance;
    logic [CELL_W-1:0]   data;
  } instr_t;

  typedef struct {
    logic [IDX_W-1:0]    next_index;
    logic [CELL_W-1:0]   out_byte;
    logic                emitted;
  } step_result_t;

  localparam int LONG_HOLD = 400;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [FUNC_W-1:0]   in_func = '0;
  logic [DIST_W-1:0]   in_jump_distance = '0;
  logic [CELL_W-1:0]   in_in_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [IDX_W-1:0]    out_next_index;
  logic [CELL_W-1:0]   out_out_byte;
  logic                out_out_valid;
  logic                cfg_we = 1'b0;
  logic [START_W-1:0]  cfg_wdata = '0;

  // Shadow copy of the machine state.
  logic [CELL_W-1:0]   tape_model [TAPE_DEPTH];
  logic [TAPE_AW-1:0]  ptr_model;
  logic [IDX_W-1:0]    index_model;

  instr_t              program_q [$];
  step_result_t        expected_steps [$];
  instr_t              issued;
  step_result_t        want;

  bit                  sender_gaps = 1'b1;
  bit                  receiver_stalls = 1'b1;
  int                  hold_token = 0;
  int                  hold_seen = 0;
  int                  hold_left = 0;
  int                  stall_left = 0;
  int                  gap_left = 0;

  int                  mismatches = 0;
  int                  queued_total = 0;
  int                  op_count [8];
  int                  bytes_emitted = 0;
  int                  jumps_taken = 0;
  int                  clamped_top = 0;
  int                  clamped_bottom = 0;
  int                  start_writes = 0;

  tape_machine_executor dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_jump_distance (in_jump_distance),
    .in_in_byte       (in_in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_next_index   (out_next_index),
    .out_out_byte     (out_out_byte),
    .out_out_valid    (out_out_valid),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic log_mismatch(input string what, input logic [15:0] got,
                              input logic [15:0] exp_v);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, exp_v);
    mismatches++;
  endtask

  // Executes one instruction on the shadow state and records the result it must give.
  task automatic execute_on_model(input instr_t ins);
    logic [CELL_W-1:0] cur_cell;
    logic [IDX_W:0]    base;
    logic [IDX_W:0]    nxt;
    logic [IDX_W:0]    jump_ext;
    step_result_t      res;
    cur_cell = tape_model[ptr_model];
    jump_ext = (IDX_W+1)'(ins.distance);
    base = {1'b0, index_model} + (IDX_W+1)'(1);
    if (base > (IDX_W+1)'(PROGRAM_DEPTH)) base = (IDX_W+1)'(PROGRAM_DEPTH);
    nxt = base;
    res.out_byte = '0;
    res.emitted = 1'b0;
    unique case (ins.op)
      FUNC_RIGHT: ptr_model = ptr_model + TAPE_AW'(1);
      FUNC_LEFT:  ptr_model = ptr_model - TAPE_AW'(1);
      FUNC_INC:   tape_model[ptr_model] = cur_cell + CELL_W'(1);
      FUNC_DEC:   tape_model[ptr_model] = cur_cell - CELL_W'(1);
      FUNC_OUT: begin
        res.out_byte = cur_cell;
        res.emitted = 1'b1;
        bytes_emitted++;
      end
      FUNC_IN:    tape_model[ptr_model] = ins.data;
      FUNC_JZ: begin
        if (cur_cell == '0) begin
          jumps_taken++;
          nxt = base + jump_ext;
          if (nxt > (IDX_W+1)'(PROGRAM_DEPTH)) begin
            nxt = (IDX_W+1)'(PROGRAM_DEPTH);
            clamped_top++;
          end
        end
      end
      FUNC_JNZ: begin
        if (cur_cell != '0) begin
          jumps_taken++;
          if (jump_ext > base) begin
            nxt = '0;
            clamped_bottom++;
          end else begin
            nxt = base - jump_ext;
          end
        end
      end
      default: ;
    endcase
    op_count[ins.op]++;
    index_model = nxt[IDX_W-1:0];
    res.next_index = nxt[IDX_W-1:0];
    expected_steps.push_back(res);
  endtask

  // Driver: presents queued instructions, with an optional gap after each transaction.
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      execute_on_model(issued);
      gap_left = sender_gaps ? $urandom_range(0, 16) : 0;
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (program_q.size() != 0) begin
        issued = program_q.pop_front();
        in_valid <= 1'b1;
        in_func <= issued.op;
        in_jump_distance <= issued.distance;
        in_in_byte <= issued.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transaction and paces out_ready.
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (expected_steps.size() == 0) begin
        log_mismatch("result with none outstanding, next_index", 16'(out_next_index), '0);
      end else begin
        want = expected_steps.pop_front();
        if (out_next_index !== want.next_index)
          log_mismatch("next_index", 16'(out_next_index), 16'(want.next_index));
        if (out_out_byte !== want.out_byte)
          log_mismatch("out_byte", 16'(out_out_byte), 16'(want.out_byte));
        if (out_out_valid !== want.emitted)
          log_mismatch("out_valid flag", 16'(out_out_valid), 16'(want.emitted));
      end
      stall_left = receiver_stalls ? $urandom_range(0, 16) : 0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic queue_instr(input func_t op, input int distance, input int data);
    instr_t ins;
    ins.op = op;
    ins.distance = DIST_W'(distance);
    ins.data = CELL_W'(data);
    program_q.push_back(ins);
    queued_total++;
  endtask

  function automatic int pick_dist();
    int sel;
    sel = $urandom_range(0, 3);
    if (sel < 2) return $urandom_range(0, 15);
    if (sel == 2) return $urandom_range(0, 4095);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 4095;
      2: return 2048;
      default: return 1;
    endcase
  endfunction

  function automatic int pick_byte();
    if ($urandom_range(0, 3) != 0) return $urandom_range(0, 255);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 255;
      2: return 128;
      default: return 1;
    endcase
  endfunction

  // Half counted loops that run to completion, half arbitrary instructions.
  task automatic add_random(input int count);
    int target;
    int trips;
    int span;
    bit shifted_body;
    target = queued_total + count;
    while (queued_total < target) begin
      if ($urandom_range(0, 1)) begin
        trips = $urandom_range(1, 4);
        shifted_body = 1'($urandom_range(0, 1));
        span = shifted_body ? 5 : 3;
        queue_instr(FUNC_IN, pick_dist(), trips);
        queue_instr(FUNC_JZ, span + 1, pick_byte());
        repeat (trips) begin
          if (shifted_body) begin
            queue_instr(FUNC_RIGHT, pick_dist(), pick_byte());
            queue_instr(FUNC_INC, pick_dist(), pick_byte());
            queue_instr(FUNC_LEFT, pick_dist(), pick_byte());
          end else begin
            queue_instr(FUNC_OUT, pick_dist(), pick_byte());
          end
          queue_instr(FUNC_DEC, pick_dist(), pick_byte());
          queue_instr(FUNC_JNZ, span, pick_byte());
        end
      end else begin
        queue_instr(func_t'($urandom_range(0, 7)), pick_dist(), pick_byte());
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (program_q.size() != 0 || in_valid || expected_steps.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_start_cell(input logic [START_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    ptr_model = value[TAPE_AW-1:0];
    start_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    #2_000_000;
    $display("tape_machine_executor regression: fail");
    $finish;
  end

  initial begin
    for (int i = 0; i < TAPE_DEPTH; i++) tape_model[i] = '0;
    for (int i = 0; i < 8; i++) op_count[i] = 0;
    ptr_model = START_CELL_RESET[TAPE_AW-1:0];
    index_model = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: saturation at both ends, wrap of cell arithmetic, untaken jumps,
    // and steps executed after the program end.
    queue_instr(FUNC_OUT, 0, 0);
    queue_instr(FUNC_JZ, 4095, 0);
    queue_instr(FUNC_INC, 0, 255);
    queue_instr(FUNC_JNZ, 0, 0);
    queue_instr(FUNC_JNZ, 4095, 0);
    queue_instr(FUNC_DEC, 4095, 0);
    queue_instr(FUNC_DEC, 0, 0);
    queue_instr(FUNC_OUT, 0, 0);
    queue_instr(FUNC_INC, 0, 0);
    queue_instr(FUNC_JZ, 0, 0);
    queue_instr(FUNC_IN, 0, 255);
    queue_instr(FUNC_OUT, 4095, 0);
    queue_instr(FUNC_JZ, 7, 0);
    queue_instr(FUNC_JNZ, 4095, 255);
    queue_instr(FUNC_IN, 4095, 0);
    queue_instr(FUNC_JNZ, 3, 0);
    queue_instr(FUNC_RIGHT, 0, 0);
    queue_instr(FUNC_IN, 0, 128);
    queue_instr(FUNC_OUT, 0, 0);
    queue_instr(FUNC_LEFT, 0, 0);
    queue_instr(FUNC_OUT, 0, 0);
    queue_instr(FUNC_JZ, 2048, 0);
    wait_drained();

    // Pointer wrap below zero and back.
    write_start_cell('0);
    queue_instr(FUNC_LEFT, 0, 0);
    queue_instr(FUNC_IN, 0, 8'h3c);
    queue_instr(FUNC_OUT, 0, 0);
    queue_instr(FUNC_RIGHT, 0, 0);
    queue_instr(FUNC_OUT, 0, 0);
    add_random(250);
    wait_drained();

    // Pointer wrap past the top, then a phase with no sender gaps.
    write_start_cell('1);
    sender_gaps <= 1'b0;
    queue_instr(FUNC_RIGHT, 0, 0);
    queue_instr(FUNC_OUT, 0, 0);
    queue_instr(FUNC_LEFT, 0, 0);
    queue_instr(FUNC_OUT, 0, 0);
    add_random(250);
    wait_drained();

    // Back-pressure: the receiver holds off while the sender keeps offering.
    write_start_cell(START_W'($urandom));
    receiver_stalls <= 1'b0;
    hold_token <= hold_token + 1;
    add_random(80);
    wait_drained();
    sender_gaps <= 1'b1;
    add_random(170);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      write_start_cell(ph == 3 ? START_CELL_RESET : START_W'($urandom));
      sender_gaps <= 1'($urandom_range(0, 1));
      receiver_stalls <= 1'($urandom_range(0, 1));
      add_random(225);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("%0d instructions, %0d start cells, per op: %0d %0d %0d %0d %0d %0d %0d %0d",
             queued_total, start_writes, op_count[0], op_count[1], op_count[2], op_count[3],
             op_count[4], op_count[5], op_count[6], op_count[7]);
    $display("%0d output bytes, %0d taken jumps, %0d clamped at the end, %0d clamped at zero",
             bytes_emitted, jumps_taken, clamped_top, clamped_bottom);
    if (mismatches == 0) begin
      $display("tape_machine_executor regression: pass");
    end else begin
      $display("tape_machine_executor regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tme_pkg.sv
sv/tme_ram.sv
sv/tape_machine_executor.sv
sv/tme_checker.sv
sim/tb_tape_machine_executor.sv
